[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL, included by rational_time_common_base.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[hw/rtl/rtcb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rtcb_pkg;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned BASE_W  = 31;

   typedef struct packed {
      logic signed [VALUE_W-1:0] lhs_value;
      logic        [BASE_W-1:0]  lhs_base;
      logic signed [VALUE_W-1:0] rhs_value;
      logic        [BASE_W-1:0]  rhs_base;
   } req_type;

   typedef struct packed {
      logic        [BASE_W-1:0]  common_base;
      logic signed [VALUE_W-1:0] lhs_rebased;
      logic signed [VALUE_W-1:0] rhs_rebased;
      logic                      used_fallback;
      logic                      saturated;
   } rsp_type;
endpackage
`default_nettype wire

[hw/rtl/rational_time_common_base.sv]
`timescale 1ns / 1ps
`default_nettype none
// Rebases two rational timestamps onto one shared denominator.
// Input: pulse start with req_payload while busy is low; the transfer is
//   taken at that edge and busy rises until the result is out.
// Result: rsp_valid is high for one cycle with rsp_payload; the receiver
//   must take it then, it cannot stall the block.
// Config: csr_we with csr_wdata writes the fallback base (reset 600);
//   write only while busy is low.
// Work per item, all bit serial, the multiplies and the value divides sharing
//   one wide accumulator: gcd by Euclid, each remainder a restoring divide
//   plus a swap (k steps, at most about 45 for 31-bit bases), one exit,
//   lb / gcd by restoring divide, lcm by a shift-add multiply and compare,
//   then per operand a shift-add multiply with load and exit, a restoring
//   divide plus exit, one clamp.
// One item at a time; a new transfer is taken once busy is low again, in
//   the cycle after the result.
// Reset returns the sequencer to idle and the register to 600.
module rational_time_common_base
   import rtcb_pkg::*;
#(
   parameter int unsigned VALUE_BITS = 64,
   parameter int unsigned BASE_BITS  = 31
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   output rsp_type      rsp_payload,
   input  wire logic    csr_we,
   input  wire logic [BASE_BITS-1:0] csr_wdata
);
`include "assert_macros.svh"

   localparam int unsigned PW = VALUE_BITS + BASE_BITS;   // product width
   localparam int unsigned CW = $clog2(PW + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_GCD, S_LCM, S_CMP, S_MUL, S_DIV, S_SAT, S_DONE
   } state_type;

   state_type              state_ff;
   logic [BASE_BITS-1:0]   fb_ff;
   logic [BASE_BITS-1:0]   lb_ff, rb_ff;
   logic [VALUE_BITS-1:0]  lv_ff, rv_ff;
   // Euclid operands and remainder
   logic [BASE_BITS-1:0]   ga_ff, gb_ff, grem_ff, gquo_ff;
   // shared wide shift registers
   logic [PW-1:0]          acc_ff, mcand_ff;
   logic [BASE_BITS:0]     rem_ff;
   logic [BASE_BITS-1:0]   mplr_ff;
   logic [CW-1:0]          cnt_ff;
   logic                   side_ff;   // 0 lhs, 1 rhs
   logic                   neg_ff;
   logic [BASE_BITS-1:0]   common_ff;
   logic                   fbk_ff, sat_ff;
   logic [VALUE_BITS-1:0]  lres_ff;
   logic                   valid_ff;
   rsp_type                out_ff;

   logic [BASE_BITS:0]     gtrial, dtrial;
   logic [BASE_BITS-1:0]   cur_base, cur_fb;
   logic [VALUE_BITS-1:0]  cur_val, mag;
   logic [VALUE_BITS-1:0]  limit, qv, res;
   logic                   ovf;

   assign cur_fb   = (fb_ff == '0) ? BASE_BITS'(1) : fb_ff;
   assign cur_base = side_ff ? rb_ff : lb_ff;
   assign cur_val  = side_ff ? rv_ff : lv_ff;
   assign mag      = cur_val[VALUE_BITS-1] ? (~cur_val + 1'b1) : cur_val;
   // one restoring step: shift the next bit of the dividend in
   assign gtrial   = {grem_ff, ga_ff[BASE_BITS-1]} - {1'b0, gb_ff};
   assign dtrial   = {rem_ff[BASE_BITS-1:0], acc_ff[PW-1]} - {1'b0, cur_base};
   assign limit    = neg_ff ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                            : {1'b0, {(VALUE_BITS-1){1'b1}}};
   assign ovf      = (acc_ff[PW-1:VALUE_BITS] != '0) || (acc_ff[VALUE_BITS-1:0] > limit);
   assign qv       = ovf ? limit : acc_ff[VALUE_BITS-1:0];
   assign res      = neg_ff ? (~qv + 1'b1) : qv;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fb_ff    <= BASE_BITS'(600);
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         if (csr_we) fb_ff <= csr_wdata;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  lv_ff   <= req_payload.lhs_value[VALUE_BITS-1:0];
                  rv_ff   <= req_payload.rhs_value[VALUE_BITS-1:0];
                  lb_ff   <= (req_payload.lhs_base[BASE_BITS-1:0] == '0) ? BASE_BITS'(1)
                             : req_payload.lhs_base[BASE_BITS-1:0];
                  rb_ff   <= (req_payload.rhs_base[BASE_BITS-1:0] == '0) ? BASE_BITS'(1)
                             : req_payload.rhs_base[BASE_BITS-1:0];
                  ga_ff   <= (req_payload.lhs_base[BASE_BITS-1:0] == '0) ? BASE_BITS'(1)
                             : req_payload.lhs_base[BASE_BITS-1:0];
                  gb_ff   <= (req_payload.rhs_base[BASE_BITS-1:0] == '0) ? BASE_BITS'(1)
                             : req_payload.rhs_base[BASE_BITS-1:0];
                  grem_ff <= '0;
                  gquo_ff <= '0;
                  cnt_ff  <= '0;
                  sat_ff  <= 1'b0;
                  side_ff <= 1'b0;
                  state_ff <= S_GCD;
               end
            end
            // Euclid: serial remainder of ga by gb, then swap
            S_GCD: begin
               if (gb_ff == '0) begin
                  // ga holds gcd; lcm = (lb / gcd) * rb, divide first
                  acc_ff   <= {{(PW-BASE_BITS){1'b0}}, lb_ff};
                  rem_ff   <= '0;
                  gquo_ff  <= '0;
                  gb_ff    <= ga_ff;
                  grem_ff  <= '0;
                  ga_ff    <= lb_ff;
                  cnt_ff   <= '0;
                  state_ff <= S_LCM;
               end else if (cnt_ff == CW'(BASE_BITS)) begin
                  ga_ff   <= gb_ff;
                  gb_ff   <= grem_ff;
                  grem_ff <= '0;
                  cnt_ff  <= '0;
               end else begin
                  grem_ff <= gtrial[BASE_BITS] ? {grem_ff[BASE_BITS-2:0], ga_ff[BASE_BITS-1]}
                                               : gtrial[BASE_BITS-1:0];
                  ga_ff   <= {ga_ff[BASE_BITS-2:0], 1'b0};
                  cnt_ff  <= cnt_ff + 1'b1;
               end
            end
            // lb / gcd, quotient collected serially
            S_LCM: begin
               if (cnt_ff == CW'(BASE_BITS)) begin
                  mplr_ff  <= rb_ff;
                  mcand_ff <= {{(PW-BASE_BITS){1'b0}}, gquo_ff};
                  acc_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_CMP;
               end else begin
                  grem_ff <= gtrial[BASE_BITS] ? {grem_ff[BASE_BITS-2:0], ga_ff[BASE_BITS-1]}
                                               : gtrial[BASE_BITS-1:0];
                  gquo_ff <= {gquo_ff[BASE_BITS-2:0], ~gtrial[BASE_BITS]};
                  ga_ff   <= {ga_ff[BASE_BITS-2:0], 1'b0};
                  cnt_ff  <= cnt_ff + 1'b1;
               end
            end
            // quotient * rb by shift-add, then choose the base
            S_CMP: begin
               if (cnt_ff == CW'(BASE_BITS)) begin
                  fbk_ff    <= acc_ff > {{(PW-BASE_BITS){1'b0}}, cur_fb};
                  common_ff <= (acc_ff > {{(PW-BASE_BITS){1'b0}}, cur_fb}) ? cur_fb
                               : acc_ff[BASE_BITS-1:0];
                  cnt_ff    <= '0;
                  state_ff  <= S_MUL;
                  acc_ff    <= '0;
                  mplr_ff   <= '0;
                  neg_ff    <= 1'b0;
               end else begin
                  if (mplr_ff[0]) acc_ff <= acc_ff + mcand_ff;
                  mcand_ff <= {mcand_ff[PW-2:0], 1'b0};
                  mplr_ff  <= {1'b0, mplr_ff[BASE_BITS-1:1]};
                  cnt_ff   <= cnt_ff + 1'b1;
               end
            end
            // |value| * common, one multiplier bit per cycle
            S_MUL: begin
               if (cnt_ff == '0 && mplr_ff == '0 && acc_ff == '0) begin
                  neg_ff   <= cur_val[VALUE_BITS-1];
                  mcand_ff <= {{BASE_BITS{1'b0}}, mag};
                  mplr_ff  <= common_ff;
                  cnt_ff   <= cnt_ff + 1'b1;
               end else if (cnt_ff == CW'(BASE_BITS + 1)) begin
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end else begin
                  if (mplr_ff[0]) acc_ff <= acc_ff + mcand_ff;
                  mcand_ff <= {mcand_ff[PW-2:0], 1'b0};
                  mplr_ff  <= {1'b0, mplr_ff[BASE_BITS-1:1]};
                  cnt_ff   <= cnt_ff + 1'b1;
               end
            end
            // restoring divide by the base, quotient shifts into acc
            S_DIV: begin
               if (cnt_ff == CW'(PW)) begin
                  state_ff <= S_SAT;
               end else begin
                  rem_ff <= dtrial[BASE_BITS] ? {rem_ff[BASE_BITS-1:0], acc_ff[PW-1]}
                                              : dtrial;
                  acc_ff <= {acc_ff[PW-2:0], ~dtrial[BASE_BITS]};
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            // clamp and sign, then move to the rhs operand or, after it, register the result
            S_SAT: begin
               if (ovf) sat_ff <= 1'b1;
               if (!side_ff) begin
                  lres_ff  <= res;
                  side_ff  <= 1'b1;
                  acc_ff   <= '0;
                  mplr_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_MUL;
               end else begin
                  out_ff.common_base   <= common_ff;
                  out_ff.lhs_rebased   <= lres_ff;
                  out_ff.rhs_rebased   <= res;
                  out_ff.used_fallback <= fbk_ff;
                  out_ff.saturated     <= sat_ff | ovf;
                  valid_ff <= 1'b1;
                  state_ff <= S_DONE;
               end
            end
            S_DONE:  state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = valid_ff;
   assign rsp_payload = out_ff;

   `ASSERT_IMPL(a_rsp_one_cycle, clock, reset, rsp_valid |=> !rsp_valid)
   `ASSERT_IMPL(a_rsp_after_sat, clock, reset, rsp_valid |-> $past(state_ff == S_SAT))
   `ASSERT_IMPL(a_busy_after_start, clock, reset, (start && !busy) |=> busy)
   `ASSERT_IMPL(a_idle_after_rsp, clock, reset, rsp_valid |=> !busy)
endmodule
`default_nettype wire

[test/rational_time_common_base_tb.sv]
`timescale 1ns / 1ps
module rational_time_common_base_tb;
   import rtcb_pkg::*;

   localparam logic signed [63:0] VMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] VMIN = 64'sh8000_0000_0000_0000;
   localparam logic [30:0] BMAX = 31'h7FFF_FFFF;
   localparam int DRAIN_CYCLES = 4000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_payload;
   logic rsp_valid;
   rsp_type rsp_payload;
   logic csr_we;
   logic [30:0] csr_wdata;

   logic [30:0] fallback_base;
   rsp_type rebase_q[$];
   int errors;

   rational_time_common_base u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // value * mult / div, truncated toward zero, clamped to 64-bit signed
   function automatic logic [63:0] rescale_value(input logic [63:0] v, input logic [30:0] mult,
                                                 input logic [30:0] div, inout bit sat);
      logic neg;
      logic [63:0] mag;
      logic [127:0] prod;
      logic [127:0] quo;
      logic [127:0] lim;
      neg = v[63];
      mag = neg ? -v : v;
      prod = {64'd0, mag} * {97'd0, mult};
      quo = prod / {97'd0, div};
      lim = neg ? 128'h8000_0000_0000_0000 : 128'h7FFF_FFFF_FFFF_FFFF;
      if (quo > lim) begin
         quo = lim;
         sat = 1'b1;
      end
      return neg ? -quo[63:0] : quo[63:0];
   endfunction

   function automatic rsp_type predict_rebase(input req_type r, input logic [30:0] fb_reg);
      rsp_type o;
      logic [62:0] lb, rb, fb, a, b, t, lcm;
      bit sat;
      lb = (r.lhs_base == 0) ? 63'd1 : {32'd0, r.lhs_base};
      rb = (r.rhs_base == 0) ? 63'd1 : {32'd0, r.rhs_base};
      fb = (fb_reg == 0) ? 63'd1 : {32'd0, fb_reg};
      a = lb;
      b = rb;
      while (b != 0) begin
         t = b;
         b = a % b;
         a = t;
      end
      lcm = (lb / a) * rb;
      o.used_fallback = lcm > fb;
      o.common_base = o.used_fallback ? fb[30:0] : lcm[30:0];
      sat = 1'b0;
      o.lhs_rebased = rescale_value(r.lhs_value, o.common_base, lb[30:0], sat);
      o.rhs_rebased = rescale_value(r.rhs_value, o.common_base, rb[30:0], sat);
      o.saturated = sat;
      return o;
   endfunction

   // check every result transfer against the oldest expectation
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid) begin
         if (rebase_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_payload);
            errors++;
         end else begin
            exp_r = rebase_q.pop_front();
            if (rsp_payload.common_base !== exp_r.common_base) begin
               $display("%0t: common_base exp %0d got %0d", $time,
                        exp_r.common_base, rsp_payload.common_base);
               errors++;
            end
            if (rsp_payload.lhs_rebased !== exp_r.lhs_rebased) begin
               $display("%0t: lhs_rebased exp %0d got %0d", $time,
                        exp_r.lhs_rebased, rsp_payload.lhs_rebased);
               errors++;
            end
            if (rsp_payload.rhs_rebased !== exp_r.rhs_rebased) begin
               $display("%0t: rhs_rebased exp %0d got %0d", $time,
                        exp_r.rhs_rebased, rsp_payload.rhs_rebased);
               errors++;
            end
            if (rsp_payload.used_fallback !== exp_r.used_fallback) begin
               $display("%0t: used_fallback exp %0b got %0b", $time,
                        exp_r.used_fallback, rsp_payload.used_fallback);
               errors++;
            end
            if (rsp_payload.saturated !== exp_r.saturated) begin
               $display("%0t: saturated exp %0b got %0b", $time,
                        exp_r.saturated, rsp_payload.saturated);
               errors++;
            end
         end
      end
   end

   // drive one transfer; typed expectation used when given, else predicted
   task automatic send_item(input req_type r, input bit typed, input rsp_type typed_rsp,
                            input bit gaps);
      int gap;
      // wait for the block to go idle, then maybe idle a little longer
      while (busy) @(negedge clock);
      if (gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_payload <= r;
      // busy is low here, so the next rising edge takes the transfer
      @(posedge clock);
      rebase_q.push_back(typed ? typed_rsp : predict_rebase(r, fallback_base));
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic wait_idle();
      while (rebase_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_fallback(input logic [30:0] v);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= v;
      fallback_base = v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] rand_value();
      case ($urandom_range(0, 5))
         0: return VMAX;
         1: return VMIN;
         2: return {{32{1'b0}}, $urandom()} - 64'd2147483648;
         3: return 64'($signed($urandom_range(0, 2000))) - 64'd1000;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic logic [30:0] rand_base();
      case ($urandom_range(0, 6))
         0: return 31'd0;
         1: return BMAX;
         2: return 31'($urandom());
         3: return 31'($urandom_range(1, 1000));
         default: begin
            case ($urandom_range(0, 5))
               0: return 31'd24;
               1: return 31'd25;
               2: return 31'd30;
               3: return 31'd48;
               4: return 31'd1000;
               default: return 31'($urandom_range(1, 60));
            endcase
         end
      endcase
   endfunction

   typedef struct {
      req_type req;
      bit typed;
      rsp_type rsp;
   } stim_row_type;

   function automatic stim_row_type mk(input logic [63:0] lv, input logic [30:0] lb,
                                       input logic [63:0] rv, input logic [30:0] rb,
                                       input bit typed, input logic [30:0] cb,
                                       input logic [63:0] lr, input logic [63:0] rr,
                                       input bit fbk, input bit sat);
      stim_row_type s;
      s.req = '{lhs_value: lv, lhs_base: lb, rhs_value: rv, rhs_base: rb};
      s.typed = typed;
      s.rsp = '{common_base: cb, lhs_rebased: lr, rhs_rebased: rr,
                used_fallback: fbk, saturated: sat};
      return s;
   endfunction

   initial begin
      stim_row_type dir_rows[$];
      req_type r;
      rsp_type none;
      int n;
      errors = 0;
      none = '0;
      start = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      fallback_base = 31'd600;
      reset = 1'b1;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows: extremes, zero bases, fallback, clamping
      dir_rows.push_back(mk(64'd1, 31'd1, 64'd1, 31'd1, 1, 31'd1, 64'd1, 64'd1, 0, 0));
      dir_rows.push_back(mk(64'd5, 31'd0, -64'd7, 31'd0, 1, 31'd1, 64'd5, -64'd7, 0, 0));
      dir_rows.push_back(mk(64'd10, 31'd24, 64'd10, 31'd25, 1, 31'd600, 64'd250, 64'd240, 0, 0));
      dir_rows.push_back(mk(VMAX, 31'd1, VMIN, 31'd1, 1, 31'd1, VMAX, VMIN, 0, 0));
      dir_rows.push_back(mk(VMAX, 31'd1, 64'd0, 31'd2, 1, 31'd2, VMAX, 64'd0, 0, 1));
      dir_rows.push_back(mk(VMIN, 31'd1, 64'd0, 31'd2, 1, 31'd2, VMIN, 64'd0, 0, 1));
      dir_rows.push_back(mk(64'd7, 31'd601, 64'd7, 31'd1, 1, 31'd600, 64'd6, 64'd4200, 1, 0));
      dir_rows.push_back(mk(-64'd7, 31'd2, 64'd3, 31'd3, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(VMAX, BMAX, VMIN, BMAX, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(VMIN, BMAX, VMAX, 31'd1, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(-64'd1, 31'd7, 64'd1, 31'd11, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(64'h5555_5555_5555_5555, 31'h2AAA_AAAA,
                            64'hAAAA_AAAA_AAAA_AAAA, 31'h5555_5555, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk(64'd123456789, 31'd1836311903, 64'd1, 31'd1134903170,
                            0, 0, 0, 0, 0, 0));
      foreach (dir_rows[i])
         send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp, 0);

      // the predicted corner rows again under the register extremes, including zero
      write_fallback(BMAX);
      for (int i = 7; i < dir_rows.size(); i++) send_item(dir_rows[i].req, 0, none, 0);
      write_fallback(31'd0);
      for (int i = 7; i < dir_rows.size(); i++) send_item(dir_rows[i].req, 0, none, 0);
      write_fallback(31'd1);
      for (int i = 7; i < dir_rows.size(); i++) send_item(dir_rows[i].req, 0, none, 0);

      // random phases, each under a fresh register setting
      for (int ph = 0; ph < 10; ph++) begin
         case (ph % 5)
            0: write_fallback(31'd600);
            1: write_fallback(BMAX);
            2: write_fallback(31'($urandom()));
            3: write_fallback(31'($urandom_range(1, 5000)));
            default: write_fallback(31'd1);
         endcase
         n = 100;
         for (int k = 0; k < n; k++) begin
            r.lhs_value = rand_value();
            r.rhs_value = rand_value();
            r.lhs_base = rand_base();
            r.rhs_base = rand_base();
            send_item(r, 0, none, ph < 8);
            // halfway through, hold off until every result is back
            if (k == 50) wait_idle();
         end
      end
      while (rebase_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #100ms;
      $display("Mismatches found");
      $finish;
   end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/rtcb_pkg.sv
hw/rtl/rational_time_common_base.sv
test/rational_time_common_base_tb.sv
